// File: rtl/awbgn_pkg.sv
// Shared widths and constants for the white balance gain normalizer.
`timescale 1ns / 1ps
package awbgn_pkg;
   localparam int RATIO_W   = 16;
   localparam int GAIN_W    = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;
   localparam int CORR_W    = 26;           // golden * 1000 fits here
   localparam int BASE_W    = 10;           // base never exceeds 1000
   localparam int SCALE_SH  = 10;           // 1024 = unity
   localparam int GNUM_W    = CORR_W + SCALE_SH;

   localparam logic [BASE_W-1:0] PER_MILLE  = BASE_W'(1000);
   localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(16'h0400);
   localparam logic [GAIN_W-1:0] GAIN_MAX   = GAIN_W'(16'hFFFF);

   localparam logic [CSR_IDX_W-1:0] CSR_GOLDEN_RED  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_GOLDEN_BLUE = CSR_IDX_W'(1);
endpackage

// File: rtl/awb_gain_normalizer_top.sv
// Top level of the white balance gain normalizer.
// Usage: write the golden red/green and blue/green ratios on the csr_
// channel (index 0 red, 1 blue) while the block is idle; csr_ready is
// always high. Each req_ word carries a measured ratio pair; each rsp_ word
// carries the three gains (1024 = unity, saturated at 65535), their write
// flags and divide_error, in request order.
// From acceptance to rsp_valid a word passes the register that scales the
// golden ratios, 26 divider stages for the correction ratios, the base
// choice register, 36 divider stages for the gains and the output
// register. One word enters per cycle while the output is not stalled;
// the two bit-per-stage divider pipelines take a new word every cycle.
// A zero measured ratio or a zero base gives divide_error with zero gains.
// When the receiver stalls with a word held at the output, the whole
// pipeline freezes and req_ready drops in the same cycle; nothing is lost
// or repeated. Reset clears all valid bits and both golden ratios.
`timescale 1ns / 1ps
module awb_gain_normalizer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [awbgn_pkg::RATIO_W-1:0]       req_measured_red_ratio,
   input  logic [awbgn_pkg::RATIO_W-1:0]       req_measured_blue_ratio,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [awbgn_pkg::GAIN_W-1:0]        rsp_red_gain,
   output logic [awbgn_pkg::GAIN_W-1:0]        rsp_green_gain,
   output logic [awbgn_pkg::GAIN_W-1:0]        rsp_blue_gain,
   output logic                                rsp_red_write,
   output logic                                rsp_green_write,
   output logic                                rsp_blue_write,
   output logic                                rsp_divide_error,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [awbgn_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [awbgn_pkg::CSR_DAT_W-1:0]     csr_data
);
   import awbgn_pkg::*;

   localparam int D1 = CORR_W;
   localparam int D2 = GNUM_W;

   function automatic logic [GAIN_W-1:0] sat_gain(input logic [GNUM_W-1:0] q);
      return (q > GNUM_W'(GAIN_MAX)) ? GAIN_MAX : q[GAIN_W-1:0];
   endfunction

   logic advance;
   logic [RATIO_W-1:0] golden_red_ff, golden_blue_ff;

   // Input stage
   logic              s0_valid_ff, s0_err_ff;
   logic [CORR_W-1:0] s0_rnum_ff, s0_bnum_ff;
   logic [RATIO_W-1:0] s0_rden_ff, s0_bden_ff;

   // Correction ratio dividers
   logic [CORR_W-1:0] rr_quot, bb_quot;
   logic              v1_ff [D1];
   logic              e1_ff [D1];

   // Base stage
   logic              s2_valid_ff, s2_err_ff;
   logic [BASE_W-1:0] s2_base_ff;
   logic [GNUM_W-1:0] s2_rnum_ff, s2_bnum_ff;
   logic              any_low;
   logic [CORR_W-1:0] ratio_min;
   logic [BASE_W-1:0] base_in;

   // Gain dividers
   logic [GNUM_W-1:0] rg_quot, gg_quot, bg_quot;
   logic              v3_ff [D2];
   logic              e3_ff [D2];

   // Output register
   logic              rsp_valid_ff, rsp_err_ff;
   logic [GAIN_W-1:0] rsp_rg_ff, rsp_gg_ff, rsp_bg_ff;
   logic [GAIN_W-1:0] rg_in, gg_in, bg_in;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         golden_red_ff  <= '0;
         golden_blue_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_GOLDEN_RED:  golden_red_ff  <= csr_data;
            CSR_GOLDEN_BLUE: golden_blue_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_err_ff  <= (req_measured_red_ratio == '0) || (req_measured_blue_ratio == '0);
         s0_rnum_ff <= CORR_W'(golden_red_ff) * CORR_W'(PER_MILLE);
         s0_bnum_ff <= CORR_W'(golden_blue_ff) * CORR_W'(PER_MILLE);
         s0_rden_ff <= req_measured_red_ratio;
         s0_bden_ff <= req_measured_blue_ratio;
      end
   end

   awbgn_div #(.NUM_W(CORR_W), .DEN_W(RATIO_W)) u_div_rr (
      .clock(clock), .advance(advance), .num(s0_rnum_ff), .den(s0_rden_ff), .quot(rr_quot)
   );
   awbgn_div #(.NUM_W(CORR_W), .DEN_W(RATIO_W)) u_div_bb (
      .clock(clock), .advance(advance), .num(s0_bnum_ff), .den(s0_bden_ff), .quot(bb_quot)
   );

   // Valid and error bits travel beside the divider stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < D1; i++) v1_ff[i] <= 1'b0;
      end else if (advance) begin
         v1_ff[0] <= s0_valid_ff;
         for (int i = 1; i < D1; i++) v1_ff[i] <= v1_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e1_ff[0] <= s0_err_ff;
         for (int i = 1; i < D1; i++) e1_ff[i] <= e1_ff[i-1];
      end
   end

   always_comb begin
      any_low   = (rr_quot < CORR_W'(PER_MILLE)) || (bb_quot < CORR_W'(PER_MILLE));
      ratio_min = (rr_quot < bb_quot) ? rr_quot : bb_quot;
      base_in   = any_low ? ratio_min[BASE_W-1:0] : PER_MILLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= v1_ff[D1-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_err_ff  <= e1_ff[D1-1] || (base_in == '0);
         s2_base_ff <= base_in;
         s2_rnum_ff <= {rr_quot, SCALE_SH'(0)};
         s2_bnum_ff <= {bb_quot, SCALE_SH'(0)};
      end
   end

   awbgn_div #(.NUM_W(GNUM_W), .DEN_W(BASE_W)) u_div_rg (
      .clock(clock), .advance(advance), .num(s2_rnum_ff), .den(s2_base_ff), .quot(rg_quot)
   );
   awbgn_div #(.NUM_W(GNUM_W), .DEN_W(BASE_W)) u_div_gg (
      .clock(clock), .advance(advance),
      .num({(CORR_W)'(PER_MILLE), SCALE_SH'(0)}), .den(s2_base_ff), .quot(gg_quot)
   );
   awbgn_div #(.NUM_W(GNUM_W), .DEN_W(BASE_W)) u_div_bg (
      .clock(clock), .advance(advance), .num(s2_bnum_ff), .den(s2_base_ff), .quot(bg_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < D2; i++) v3_ff[i] <= 1'b0;
      end else if (advance) begin
         v3_ff[0] <= s2_valid_ff;
         for (int i = 1; i < D2; i++) v3_ff[i] <= v3_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         e3_ff[0] <= s2_err_ff;
         for (int i = 1; i < D2; i++) e3_ff[i] <= e3_ff[i-1];
      end
   end

   always_comb begin
      rg_in = e3_ff[D2-1] ? '0 : sat_gain(rg_quot);
      gg_in = e3_ff[D2-1] ? '0 : sat_gain(gg_quot);
      bg_in = e3_ff[D2-1] ? '0 : sat_gain(bg_quot);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= v3_ff[D2-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_err_ff <= e3_ff[D2-1];
         rsp_rg_ff  <= rg_in;
         rsp_gg_ff  <= gg_in;
         rsp_bg_ff  <= bg_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red_gain     = rsp_rg_ff;
   assign rsp_green_gain   = rsp_gg_ff;
   assign rsp_blue_gain    = rsp_bg_ff;
   assign rsp_red_write    = (rsp_rg_ff > UNITY_GAIN);
   assign rsp_green_write  = (rsp_gg_ff > UNITY_GAIN);
   assign rsp_blue_write   = (rsp_bg_ff > UNITY_GAIN);
   assign rsp_divide_error = rsp_err_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_error |->
         rsp_red_gain == '0 && rsp_green_gain == '0 && rsp_blue_gain == '0
         && !rsp_red_write && !rsp_green_write && !rsp_blue_write)
      else $error("error word carries a gain or write flag");

   a_green_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_divide_error |-> rsp_green_gain >= UNITY_GAIN)
      else $error("green gain below unity with base at most 1000");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready ##1 (rsp_valid && $stable(rsp_red_gain)
         && $stable(rsp_blue_gain)))
      else $error("output word changed or input taken during stall");
endmodule

// File: rtl/awbgn_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
module awbgn_div #(
   parameter int NUM_W = 26,
   parameter int DEN_W = 16
) (
   input  logic             clock,
   input  logic             advance,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quot
);
   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [NUM_W-1:0] nq_ff  [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];

   genvar s;
   generate
      for (s = 0; s < NUM_W; s++) begin : g_stage
         logic [DEN_W-1:0] rem_prev;
         logic [NUM_W-1:0] nq_prev;
         logic [DEN_W-1:0] den_prev;
         logic [DEN_W:0]   trial;
         logic [DEN_W:0]   diff;
         logic             ge;
         logic [DEN_W-1:0] rem_in;
         logic [NUM_W-1:0] nq_in;

         if (s == 0) begin : g_first
            assign rem_prev = '0;
            assign nq_prev  = num;
            assign den_prev = den;
         end else begin : g_next
            assign rem_prev = rem_ff[s-1];
            assign nq_prev  = nq_ff[s-1];
            assign den_prev = den_ff[s-1];
         end

         always_comb begin
            trial  = {rem_prev, nq_prev[NUM_W-1]};
            diff   = trial - {1'b0, den_prev};
            ge     = (trial >= {1'b0, den_prev});
            rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            nq_in  = {nq_prev[NUM_W-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[s] <= rem_in;
               nq_ff[s]  <= nq_in;
               den_ff[s] <= den_prev;
            end
         end
      end
   endgenerate

   assign quot = nq_ff[NUM_W-1];
endmodule
